### sv/rbc_pkg.sv
// Shared types and constants for the retry backoff controller.
// No dependencies; compile before the interfaces and the top level.
`default_nettype none

package rbc_pkg;

   // Field widths
   localparam int ACTION_W   = 2;
   localparam int CODE_W     = 8;
   localparam int RANDOM_W   = 31;
   localparam int ATTEMPT_W  = 4;
   localparam int DELAY_W    = 16;
   localparam int SKIP_W     = 16;
   localparam int JITTER_W   = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [ACTION_W-1:0]      action_type;
   typedef logic signed [CODE_W-1:0] code_type;
   typedef logic [RANDOM_W-1:0]      random_type;
   typedef logic [ATTEMPT_W-1:0]     attempt_type;
   typedef logic [DELAY_W-1:0]       delay_type;
   typedef logic [SKIP_W-1:0]        skip_type;
   typedef logic [JITTER_W-1:0]      jitter_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]    csr_data_type;

   // Event codes
   localparam action_type ACT_START   = 2'd0;
   localparam action_type ACT_FAILURE = 2'd1;
   localparam action_type ACT_SUCCESS = 2'd2;

   // Retryable failure codes
   localparam code_type ERR_DEADLOCK     = -8'sd1;
   localparam code_type ERR_LOCK_TIMEOUT = -8'sd2;
   localparam code_type ERR_CONFLICT     = -8'sd3;
   localparam code_type ERR_TEMPORARY    = -8'sd4;

   // Register indexes
   localparam csr_idx_type CSR_RETRY_LIMIT      = 3'd0;
   localparam csr_idx_type CSR_BASE_DELAY       = 3'd1;
   localparam csr_idx_type CSR_MAX_DELAY        = 3'd2;
   localparam csr_idx_type CSR_JITTER_PERCENT   = 3'd3;
   localparam csr_idx_type CSR_DEADLOCK_HALVING = 3'd4;

   // Register reset values
   localparam attempt_type RST_RETRY_LIMIT    = 4'd3;
   localparam delay_type   RST_BASE_DELAY     = 16'd100;
   localparam delay_type   RST_MAX_DELAY      = 16'd2000;
   localparam jitter_type  RST_JITTER_PERCENT = 7'd20;

endpackage

`default_nettype wire

### sv/rbc_req_if.sv
// Event channel: valid/ready plus one event word.
// Depends on rbc_pkg.
`default_nettype none

interface rbc_req_if;
   logic                valid;
   logic                ready;
   rbc_pkg::action_type action;
   rbc_pkg::code_type   fault_code;
   rbc_pkg::random_type random_value;

   modport source (output valid, action, fault_code, random_value, input ready);
   modport sink   (input valid, action, fault_code, random_value, output ready);
endinterface

`default_nettype wire

### sv/rbc_rsp_if.sv
// Result channel: valid/ready plus one status word.
// Depends on rbc_pkg.
`default_nettype none

interface rbc_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 retry_granted;
   rbc_pkg::attempt_type attempt_count;
   rbc_pkg::delay_type   wait_delay;
   rbc_pkg::skip_type    ok_count;
   logic                 deadlock_seen;

   modport source (output valid, retry_granted, attempt_count, wait_delay, ok_count,
                   deadlock_seen, input ready);
   modport sink   (input valid, retry_granted, attempt_count, wait_delay, ok_count,
                   deadlock_seen, output ready);
endinterface

`default_nettype wire

### sv/rbc_csr_if.sv
// Register write channel: valid/ready plus index and data.
// Depends on rbc_pkg.
`default_nettype none

interface rbc_csr_if;
   logic                  valid;
   logic                  ready;
   rbc_pkg::csr_idx_type  index;
   rbc_pkg::csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/retry_backoff_controller.sv
// Retry controller with capped exponential backoff and jitter.
// Depends on rbc_pkg, rbc_req_if, rbc_rsp_if and rbc_csr_if.
`default_nettype none

// Each event word on req_bus yields exactly one status word on rsp_bus. A start
// event or a granted failure recomputes the delay: base_delay shifted by the
// attempt count, capped at max_delay, then jittered by random_value modulo
// (2r+1) where r = delay*jitter_percent/100, clamped to [base_delay, max_delay]
// when jitter is on, and halved after a deadlock when deadlock_halving is set.
// The divide by 100 is a reciprocal multiply; the modulo runs on one restoring
// divider, one bit per cycle (31 steps). With jitter_percent at zero the
// multiply and the divider are skipped, and refused failures, success and
// unused events skip the delay path. The block handles one event at a time;
// the status word sits in an output register, so the next event is taken while
// it waits for rsp_bus.ready, and a second finished word holds the block busy
// until that register frees up. Register writes are always ready and must be
// issued only while no event is in flight.

module retry_backoff_controller (
   input  wire logic clock,
   input  wire logic reset,
   rbc_req_if.sink   req_bus,
   rbc_rsp_if.source rsp_bus,
   rbc_csr_if.sink   csr_bus
);
   import rbc_pkg::*;

   // Sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_DIVM  = 3'd4;
   localparam logic [2:0] ST_FIX   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam int SHIFT_W = DELAY_W + (1 << ATTEMPT_W) - 1;  // base << 15
   localparam int PROD_W  = DELAY_W + JITTER_W;
   localparam int RANGE_W = 17;                               // r <= 65535*127/100
   localparam int DIV_W   = RANGE_W + 1;                      // 2r+1
   localparam int SUM_W   = 20;
   localparam int CNT_W   = 5;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;

   localparam logic [CNT_W-1:0] MOD_STEPS = CNT_W'(RANDOM_W);
   // ceil(2^30/100): exact floor(x/100) for every product below 2^23
   localparam logic [RECIP_W-1:0] PERCENT_RECIP = 24'd10737419;

   // Configuration registers
   attempt_type max_att_ff;
   delay_type   base_ff;
   delay_type   maxd_ff;
   jitter_type  jitter_ff;
   logic        halving_ff;

   // Architectural state
   logic [2:0]  state_ff, state_in;
   attempt_type attempt_ff, attempt_in;
   delay_type   delay_ff, delay_in;
   logic        dead_ff, dead_in;
   skip_type    succ_ff, succ_in;
   logic        granted_ff, granted_in;

   // Datapath
   random_type          rnd_ff, rnd_in;
   delay_type           d_ff, d_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [RANGE_W-1:0]  range_ff, range_in;
   logic [RANDOM_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    divisor_ff, divisor_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        o_granted_ff, o_granted_in;
   attempt_type o_attempt_ff, o_attempt_in;
   delay_type   o_delay_ff, o_delay_in;
   skip_type    o_skip_ff, o_skip_in;
   logic        o_dead_ff, o_dead_in;

   // Divider step and delay helpers
   logic [DIV_W:0]        trial;
   logic [DIV_W:0]        diff;
   logic                  ge;
   logic [SHIFT_W-1:0]    shifted;
   logic [PROD_W+RECIP_W-1:0] scaled;
   logic signed [SUM_W-1:0] sum;
   delay_type             clamped;
   logic                  retryable;
   logic                  accept;
   logic                  out_free;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.retry_granted = o_granted_ff;
   assign rsp_bus.attempt_count = o_attempt_ff;
   assign rsp_bus.wait_delay    = o_delay_ff;
   assign rsp_bus.ok_count      = o_skip_ff;
   assign rsp_bus.deadlock_seen = o_dead_ff;

   assign retryable = (req_bus.fault_code == ERR_DEADLOCK)
                   || (req_bus.fault_code == ERR_LOCK_TIMEOUT)
                   || (req_bus.fault_code == ERR_CONFLICT)
                   || (req_bus.fault_code == ERR_TEMPORARY);

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign trial = {rem_ff, num_ff[RANDOM_W-1]};
   assign ge    = (trial >= {1'b0, divisor_ff});
   assign diff  = trial - {1'b0, divisor_ff};

   assign shifted = {{(SHIFT_W-DELAY_W){1'b0}}, base_ff} << attempt_ff;

   // delay*jitter/100 by reciprocal multiply
   assign scaled = {{RECIP_W{1'b0}}, prod_ff} * {{PROD_W{1'b0}}, PERCENT_RECIP};

   // d + (rnd mod span) - r, signed; then clamp low to base, high to max
   assign sum = $signed({{(SUM_W-DELAY_W){1'b0}}, d_ff})
              + $signed({{(SUM_W-DIV_W){1'b0}}, rem_ff})
              - $signed({{(SUM_W-RANGE_W){1'b0}}, range_ff});

   always_comb begin
      if (sum < $signed({{(SUM_W-DELAY_W){1'b0}}, base_ff})) begin
         clamped = base_ff;
      end else if (sum > $signed({{(SUM_W-DELAY_W){1'b0}}, maxd_ff})) begin
         clamped = maxd_ff;
      end else begin
         clamped = sum[DELAY_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      attempt_in   = attempt_ff;
      delay_in     = delay_ff;
      dead_in      = dead_ff;
      succ_in      = succ_ff;
      granted_in   = granted_ff;
      rnd_in       = rnd_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      range_in     = range_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      o_granted_in = o_granted_ff;
      o_attempt_in = o_attempt_ff;
      o_delay_in   = o_delay_ff;
      o_skip_in    = o_skip_ff;
      o_dead_in    = o_dead_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rnd_in     = req_bus.random_value;
               granted_in = 1'b0;
               state_in   = ST_DONE;
               case (req_bus.action)
                  ACT_START: begin
                     attempt_in = '0;
                     dead_in    = 1'b0;
                     succ_in    = '0;
                     state_in   = ST_SHIFT;
                  end
                  ACT_FAILURE: begin
                     // Refused once the attempt budget is spent: leave state alone
                     if (attempt_ff < max_att_ff) begin
                        dead_in = (req_bus.fault_code == ERR_DEADLOCK);
                        if (retryable) begin
                           attempt_in = attempt_ff + 1'b1;
                           succ_in    = '0;
                           granted_in = 1'b1;
                           state_in   = ST_SHIFT;
                        end
                     end
                  end
                  ACT_SUCCESS: begin
                     if (succ_ff != '1) begin
                        succ_in = succ_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // Cap the shifted base at max_delay
            if (shifted > {{(SHIFT_W-DELAY_W){1'b0}}, maxd_ff}) begin
               d_in = maxd_ff;
            end else begin
               d_in = shifted[DELAY_W-1:0];
            end
            state_in = (jitter_ff != '0) ? ST_MUL : ST_FIX;
         end
         ST_MUL: begin
            prod_in  = {{JITTER_W{1'b0}}, d_ff} * {{DELAY_W{1'b0}}, jitter_ff};
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // Take r, then load the random value for the modulo by 2r+1
            range_in   = scaled[RECIP_SHIFT +: RANGE_W];
            num_in     = rnd_ff;
            rem_in     = '0;
            divisor_in = {range_in, 1'b1};
            cnt_in     = MOD_STEPS;
            state_in   = ST_DIVM;
         end
         ST_DIVM: begin
            rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            num_in = {num_ff[RANDOM_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            delay_in = (jitter_ff != '0) ? clamped : d_ff;
            if (dead_ff && halving_ff) begin
               delay_in = delay_in >> 1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_granted_in = granted_ff;
               o_attempt_in = attempt_ff;
               o_delay_in   = delay_ff;
               o_skip_in    = succ_ff;
               o_dead_in    = dead_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         attempt_ff   <= '0;
         delay_ff     <= '0;
         dead_ff      <= 1'b0;
         succ_ff      <= '0;
         granted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         attempt_ff   <= attempt_in;
         delay_ff     <= delay_in;
         dead_ff      <= dead_in;
         succ_ff      <= succ_in;
         granted_ff   <= granted_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff       <= rnd_in;
      d_ff         <= d_in;
      prod_ff      <= prod_in;
      range_ff     <= range_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      o_granted_ff <= o_granted_in;
      o_attempt_ff <= o_attempt_in;
      o_delay_ff   <= o_delay_in;
      o_skip_ff    <= o_skip_in;
      o_dead_ff    <= o_dead_in;
   end

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         max_att_ff <= RST_RETRY_LIMIT;
         base_ff    <= RST_BASE_DELAY;
         maxd_ff    <= RST_MAX_DELAY;
         jitter_ff  <= RST_JITTER_PERCENT;
         halving_ff <= 1'b1;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_RETRY_LIMIT:      max_att_ff <= csr_bus.data[ATTEMPT_W-1:0];
            CSR_BASE_DELAY:       base_ff    <= csr_bus.data[DELAY_W-1:0];
            CSR_MAX_DELAY:        maxd_ff    <= csr_bus.data[DELAY_W-1:0];
            CSR_JITTER_PERCENT:   jitter_ff  <= csr_bus.data[JITTER_W-1:0];
            CSR_DEADLOCK_HALVING: halving_ff <= csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   // The modulo leaves a remainder below its divisor
   a_mod_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX && jitter_ff != '0) |-> (rem_ff < divisor_ff))
      else $error("jitter remainder not below span");

   // With jitter, no halving and base not above max the delay never falls below base
   a_low_clamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX && jitter_ff != '0 && !(dead_ff && halving_ff)
       && base_ff <= maxd_ff)
      |=> (delay_ff >= base_ff))
      else $error("jittered delay below base_delay");

   // An accepted event always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("event accepted without leaving idle");

   // Without jitter the sequencer never enters the divider
   a_no_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && jitter_ff == '0) |=> (state_ff == ST_FIX))
      else $error("divider entered with jitter disabled");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for retry_backoff_controller: drives event words,
// predicts every status word and compares it field by field.
// Depends on rbc_pkg, rbc_req_if, rbc_rsp_if, rbc_csr_if and the block itself.

module testbench;
   import rbc_pkg::*;

   // The event code that the block ignores; the package names only the used ones
   localparam action_type ACT_UNUSED = 2'd3;

   localparam longint PERCENT_FULL     = 100;
   localparam int     DIRECTED_ROWS    = 20;
   localparam int     FIXED_SETTINGS   = 7;
   localparam int     PHASES           = 9;
   localparam int     EVENTS_PER_PHASE = 160;
   localparam int     SKIP_TOP         = 65535;
   localparam int     LONG_HOLD_CYCLES = 300;
   localparam int     TAIL_CYCLES      = 8;
   localparam int     TIMEOUT_CYCLES   = 1_500_000;

   typedef struct packed {
      action_type action;
      code_type   code;
      random_type rnd;
   } event_word_type;

   typedef struct packed {
      logic        granted;
      attempt_type attempts;
      delay_type   wait_delay;
      skip_type    skips;
      logic        deadlock;
   } status_word_type;

   typedef struct packed {
      action_type      action;
      code_type        code;
      random_type      rnd;
      logic            typed;
      status_word_type status;
   } directed_row_type;

   typedef struct packed {
      attempt_type retry_limit;
      delay_type   base;
      delay_type   cap;
      jitter_type  jitter;
      logic        halving;
   } cfg_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rbc_req_if req_bus ();
   rbc_rsp_if rsp_bus ();
   rbc_csr_if csr_bus ();

   retry_backoff_controller dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Register copies held by the predictor; they follow every accepted write
   attempt_type cfg_retry_limit = RST_RETRY_LIMIT;
   delay_type   cfg_base        = RST_BASE_DELAY;
   delay_type   cfg_max         = RST_MAX_DELAY;
   jitter_type  cfg_jitter      = RST_JITTER_PERCENT;
   logic        cfg_halving     = 1'b1;

   // Controller state as the predictor sees it; all zero out of reset
   attempt_type attempt_now  = '0;
   delay_type   delay_now    = '0;
   logic        deadlock_now = 1'b0;
   skip_type    skip_now     = '0;

   // Status words still owed by the block, oldest first
   status_word_type status_due [$];

   int error_count     = 0;
   int words_checked   = 0;
   int events_sent     = 0;
   int retries_granted = 0;
   int settings_used   = 0;

   // Idle odds in percent, switched by the stimulus between regimes
   int sender_idle_pct   = 38;
   int receiver_idle_pct = 76;

   // Long receiver hold-offs: requested by the stimulus, served by the receiver
   int holds_requested = 0;
   int holds_served    = 0;
   int hold_left       = 0;

   // Directed events under the reset register values. Rows with typed set carry
   // a status word that follows straight from the reset state; the others go
   // through the predictor.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // success right after reset: only the skip counter moves
      '{ACT_SUCCESS, code_type'(0), 31'd0, 1'b1, '{1'b0, 4'd0, 16'd0, 16'd1, 1'b0}},
      // unused event code with every random bit high is ignored
      '{ACT_UNUSED, code_type'(-128), 31'h7FFF_FFFF, 1'b1, '{1'b0, 4'd0, 16'd0, 16'd1, 1'b0}},
      // fatal codes at both ends of the range: no retry, nothing moves
      '{ACT_FAILURE, code_type'(127), 31'd0, 1'b1, '{1'b0, 4'd0, 16'd0, 16'd1, 1'b0}},
      '{ACT_FAILURE, code_type'(-128), 31'h7FFF_FFFF, 1'b1, '{1'b0, 4'd0, 16'd0, 16'd1, 1'b0}},
      // start with the lowest jitter pick, pulled back up to the base
      '{ACT_START, code_type'(0), 31'd0, 1'b0, '0},
      // deadlock retry with the highest random value, delay halved
      '{ACT_FAILURE, ERR_DEADLOCK, 31'h7FFF_FFFF, 1'b0, '0},
      '{ACT_SUCCESS, code_type'(0), 31'd0, 1'b0, '0},
      '{ACT_SUCCESS, code_type'(0), 31'd0, 1'b0, '0},
      '{ACT_FAILURE, ERR_LOCK_TIMEOUT, 31'd12345, 1'b0, '0},
      '{ACT_FAILURE, ERR_CONFLICT, 31'd0, 1'b0, '0},
      // attempt count now at the limit: both of these are refused
      '{ACT_FAILURE, ERR_TEMPORARY, 31'h5555_5555, 1'b0, '0},
      '{ACT_FAILURE, ERR_DEADLOCK, 31'd7, 1'b0, '0},
      '{ACT_SUCCESS, code_type'(0), 31'd0, 1'b0, '0},
      '{ACT_START, code_type'(0), 31'h7FFF_FFFF, 1'b0, '0},
      '{ACT_FAILURE, ERR_DEADLOCK, 31'd40, 1'b0, '0},
      // fatal codes below the limit clear the deadlock mark only
      '{ACT_FAILURE, code_type'(0), 31'd0, 1'b0, '0},
      '{ACT_FAILURE, code_type'(-5), 31'd0, 1'b0, '0},
      '{ACT_FAILURE, ERR_TEMPORARY, 31'h2AAA_AAAA, 1'b0, '0},
      '{ACT_UNUSED, ERR_DEADLOCK, 31'd0, 1'b0, '0},
      // start ignores the error code it carries
      '{ACT_START, ERR_DEADLOCK, 31'h2AAA_AAAA, 1'b0, '0}
   };

   // Register settings for the first phases: reset values, the extremes, base
   // above max with and without jitter, and jitter above a hundred percent
   cfg_set_type fixed_settings [FIXED_SETTINGS] = '{
      '{RST_RETRY_LIMIT, RST_BASE_DELAY, RST_MAX_DELAY, RST_JITTER_PERCENT, 1'b1},
      '{4'd15, 16'd1, 16'hFFFF, 7'd100, 1'b0},
      '{4'd0, 16'd0, 16'd0, 7'd0, 1'b1},
      '{4'd15, 16'hFFFF, 16'hFFFF, 7'd127, 1'b1},
      '{4'd7, 16'd5000, 16'd300, 7'd50, 1'b1},
      '{4'd5, 16'd5000, 16'd300, 7'd0, 1'b1},
      '{4'd12, 16'd37, 16'd40000, 7'd1, 1'b0}
   };

   // Backoff delay for the given attempt count: shift, cap, jitter, clamp and
   // the deadlock halving. Work in signed 64 bits so a jitter offset that
   // dips below zero compares correctly against the clamp.
   function automatic delay_type backoff_delay(attempt_type attempts, random_type rnd,
                                               logic halve);
      longint d;
      longint base_l;
      longint cap_l;
      longint reach;
      longint offset;
      base_l = cfg_base;
      cap_l  = cfg_max;
      d = base_l << attempts;
      if (d > cap_l)
         d = cap_l;
      if (cfg_jitter != '0) begin
         reach  = (d * longint'(cfg_jitter)) / PERCENT_FULL;
         offset = (longint'(rnd) % (2 * reach + 1)) - reach;
         d = d + offset;
         // the lower clamp wins when base sits above max
         if (d < base_l)
            d = base_l;
         else if (d > cap_l)
            d = cap_l;
      end
      if (halve)
         d = d / 2;
      return delay_type'(d);
   endfunction

   // Apply one event word to the predicted state and return the status word
   // that the block owes for it.
   function automatic status_word_type advance_controller(event_word_type ev);
      status_word_type s;
      logic retryable;
      s.granted = 1'b0;
      retryable = (ev.code == ERR_DEADLOCK) || (ev.code == ERR_LOCK_TIMEOUT) ||
                  (ev.code == ERR_CONFLICT) || (ev.code == ERR_TEMPORARY);
      case (ev.action)
         ACT_START: begin
            attempt_now  = '0;
            deadlock_now = 1'b0;
            skip_now     = '0;
            delay_now    = backoff_delay(attempt_now, ev.rnd, 1'b0);
         end
         ACT_FAILURE: begin
            // refused at the limit: nothing changes, the deadlock mark included
            if (attempt_now < cfg_retry_limit) begin
               deadlock_now = (ev.code == ERR_DEADLOCK);
               if (retryable) begin
                  attempt_now = attempt_now + 1'b1;
                  delay_now   = backoff_delay(attempt_now, ev.rnd,
                                              deadlock_now && cfg_halving);
                  skip_now    = '0;
                  s.granted   = 1'b1;
               end
            end
         end
         ACT_SUCCESS: begin
            if (skip_now != skip_type'(SKIP_TOP))
               skip_now = skip_now + 1'b1;
         end
         default: begin
            // unused code: report the state as it stands
         end
      endcase
      s.attempts   = attempt_now;
      s.wait_delay = delay_now;
      s.skips      = skip_now;
      s.deadlock   = deadlock_now;
      return s;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   // Offer one event word. Start and end right after a falling edge; leave
   // valid high so back-to-back words never drop it in between.
   task automatic offer_event(event_word_type ev, logic typed, status_word_type typed_status);
      status_word_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= ev.action;
      req_bus.fault_code   <= ev.code;
      req_bus.random_value <= ev.rnd;
      do
         @(posedge clock);
      while (!req_bus.ready);
      predicted = advance_controller(ev);
      status_due.push_back(typed ? typed_status : predicted);
      retries_granted += predicted.granted;
      events_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed status word has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (status_due.size() != 0)
         @(negedge clock);
   endtask

   // Write all five registers while the block is idle and track them in the
   // predictor as each write is taken.
   task automatic write_registers(cfg_set_type s);
      csr_idx_type  idx_list  [5];
      csr_data_type data_list [5];
      idx_list  = '{CSR_RETRY_LIMIT, CSR_BASE_DELAY, CSR_MAX_DELAY, CSR_JITTER_PERCENT,
                    CSR_DEADLOCK_HALVING};
      data_list = '{csr_data_type'(s.retry_limit), s.base, s.cap,
                    csr_data_type'(s.jitter), csr_data_type'(s.halving)};
      for (int k = 0; k < 5; k++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx_list[k];
         csr_bus.data  <= data_list[k];
         do
            @(posedge clock);
         while (!csr_bus.ready);
         case (idx_list[k])
            CSR_RETRY_LIMIT:      cfg_retry_limit = attempt_type'(data_list[k]);
            CSR_BASE_DELAY:       cfg_base        = data_list[k];
            CSR_MAX_DELAY:        cfg_max         = data_list[k];
            CSR_JITTER_PERCENT:   cfg_jitter      = jitter_type'(data_list[k]);
            CSR_DEADLOCK_HALVING: cfg_halving     = data_list[k][0];
            default: ;
         endcase
         @(negedge clock);
      end
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // Receiver: drive ready at each falling edge. A requested hold-off keeps
   // ready low for a long stretch so the block backs up and stalls its input.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Compare every accepted status word with the oldest one owed
   always @(posedge clock) begin
      status_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (status_due.size() == 0) begin
            $error("status word with no event pending: attempt_count %0d, wait_delay %0d",
                   rsp_bus.attempt_count, rsp_bus.wait_delay);
            error_count++;
         end else begin
            want = status_due.pop_front();
            check_field("retry_granted", want.granted, rsp_bus.retry_granted);
            check_field("attempt_count", want.attempts, rsp_bus.attempt_count);
            check_field("wait_delay", want.wait_delay, rsp_bus.wait_delay);
            check_field("ok_count", want.skips, rsp_bus.ok_count);
            check_field("deadlock_seen", want.deadlock, rsp_bus.deadlock_seen);
            words_checked++;
         end
      end
   end

   // Stimulus: directed rows, then random phases under changing register
   // settings and idle regimes.
   initial begin
      event_word_type ev;
      cfg_set_type    setting;
      int             pick;

      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_START;
      req_bus.fault_code   = '0;
      req_bus.random_value = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_RETRY_LIMIT;
      csr_bus.data         = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         ev.action = directed_rows[r].action;
         ev.code   = directed_rows[r].code;
         ev.rnd    = directed_rows[r].rnd;
         offer_event(ev, directed_rows[r].typed, directed_rows[r].status);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         if (p < FIXED_SETTINGS) begin
            setting = fixed_settings[p];
         end else begin
            setting.retry_limit = attempt_type'($urandom_range(15));
            setting.base        = delay_type'($urandom_range(1, 500));
            setting.cap         = delay_type'($urandom_range(100, 20000));
            setting.jitter      = jitter_type'($urandom_range(100));
            setting.halving     = 1'($urandom_range(1));
         end
         write_registers(setting);

         // receiver idles more first, then the sender, then neither
         if (p < 3) begin
            sender_idle_pct   = 38;
            receiver_idle_pct = 76;
         end else if (p < 6) begin
            sender_idle_pct   = 76;
            receiver_idle_pct = 38;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         if (p == 6)
            holds_requested++;

         // Mostly well-formed retry sequences: starts, retryable failures and
         // successes; fatal codes and unused events mixed in as noise
         for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 12)
               ev.action = ACT_START;
            else if (pick < 62)
               ev.action = ACT_FAILURE;
            else if (pick < 94)
               ev.action = ACT_SUCCESS;
            else
               ev.action = ACT_UNUSED;
            if ($urandom_range(9) < 7) begin
               case ($urandom_range(3))
                  0: ev.code = ERR_DEADLOCK;
                  1: ev.code = ERR_LOCK_TIMEOUT;
                  2: ev.code = ERR_CONFLICT;
                  default: ev.code = ERR_TEMPORARY;
               endcase
            end else begin
               ev.code = code_type'($urandom);
            end
            case ($urandom_range(9))
               0: ev.rnd = '0;
               1: ev.rnd = '1;
               2: ev.rnd = random_type'($urandom_range(100));
               default: ev.rnd = random_type'($urandom);
            endcase
            offer_event(ev, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d events under %0d register settings, %0d retries granted;",
               events_sent, settings_used, retries_granted);
      $display("checked %0d status words across three idle regimes and a long stall.",
               words_checked);
      if (error_count == 0 && status_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: stop a run that hangs
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
